/* hw/rtl/flc_pkg.sv */
// ----------------------------------------------------------------------------
// flc_pkg
// Shared types and constants for the fifo lookup cache: entry layout, key
// layout, opcodes and the depth of the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package flc_pkg;

    localparam int ENTRIES  = 32;
    localparam int FILL_W   = $clog2(ENTRIES + 1);

    localparam int REF_W    = 63;
    localparam int DIM_W    = 16;
    localparam int FMT_W    = 8;
    localparam int VALUE_W  = 31;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic [REF_W-1:0] ref_id;
        logic [DIM_W-1:0] width_limit;
        logic [DIM_W-1:0] height_limit;
        logic [FMT_W-1:0] format_code;
    } key_t;

    typedef struct packed {
        key_t               key;
        logic [VALUE_W-1:0] value;
    } entry_t;

endpackage : flc_pkg

`default_nettype wire

/* hw/rtl/fifo_lookup_cache_top.sv */
// ----------------------------------------------------------------------------
// fifo_lookup_cache_top
// Fully associative result cache with first-in first-out replacement, built
// as a chain of entry cells with a registered match stage and output stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one transaction is either a lookup (s_operation 0) of
//   the key {ref_id, width_limit, height_limit, format_code} or an insert of
//   that key with s_value_in. Every transaction gives exactly one result on
//   m_*: m_hit and m_value_out of the newest matching entry, both zero on a
//   miss or an insert.
//   The accepting edge stores the per-cell compare flags in the match stage;
//   the selected result is then registered in the output stage with m_valid.
//   Throughput is one transaction per cycle while s_ready is high; an insert
//   shifts the whole cell chain when accepted, and a following lookup sees it.
//   When the receiver holds m_ready low the output register and the match
//   stage fill, after which s_ready drops; nothing is lost or reordered.
//   Reset empties the cache (fill count zero) and clears the stage valid
//   flags; entry contents stay and are never compared until written.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_lookup_cache_top
    import flc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_operation,
    input  wire logic [REF_W-1:0]   s_ref_id,
    input  wire logic [DIM_W-1:0]   s_width_limit,
    input  wire logic [DIM_W-1:0]   s_height_limit,
    input  wire logic [FMT_W-1:0]   s_format_code,
    input  wire logic [VALUE_W-1:0] s_value_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_hit,
    output logic [VALUE_W-1:0]      m_value_out
);

    key_t               query_key;
    entry_t             new_entry;
    entry_t             cell_entry [ENTRIES];
    logic [VALUE_W-1:0] cell_value [ENTRIES];
    logic [ENTRIES-1:0] cell_match;
    logic [ENTRIES-1:0] cell_valid;

    logic               s_fire;
    logic               do_insert;
    logic               do_lookup;
    logic               out_adv;
    logic               sel_found;
    logic [VALUE_W-1:0] sel_value;

    logic [FILL_W-1:0]  fill_count_reg;
    logic [FILL_W-1:0]  fill_count_next;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_op_reg;
    logic               s1_op_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic               m_hit_reg;
    logic               m_hit_next;
    logic [VALUE_W-1:0] m_value_reg;
    logic [VALUE_W-1:0] m_value_next;

    assign query_key = '{ref_id:       s_ref_id,
                         width_limit:  s_width_limit,
                         height_limit: s_height_limit,
                         format_code:  s_format_code};
    assign new_entry = '{key: query_key, value: s_value_in};

    assign out_adv   = !m_valid_reg || m_ready;
    assign s_ready   = !s1_valid_reg || out_adv;
    assign s_fire    = s_valid && s_ready;
    assign do_insert = s_fire && (s_operation == OP_INSERT);
    assign do_lookup = s_fire && (s_operation == OP_LOOKUP);

    // cell chain, position 0 is the newest entry
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        assign cell_valid[i] = (FILL_W'(i) < fill_count_reg);
        assign cell_value[i] = cell_entry[i].value;

        if (i == 0) begin : g_head
            flc_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .shift_en    (do_insert),
                .entry_in    (new_entry),
                .entry_out   (cell_entry[i]),
                .entry_valid (cell_valid[i]),
                .lookup_en   (do_lookup),
                .query_key   (query_key),
                .match_out   (cell_match[i])
            );
        end else begin : g_body
            flc_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .shift_en    (do_insert),
                .entry_in    (cell_entry[i-1]),
                .entry_out   (cell_entry[i]),
                .entry_valid (cell_valid[i]),
                .lookup_en   (do_lookup),
                .query_key   (query_key),
                .match_out   (cell_match[i])
            );
        end
    end

    // reads the cells before any insert accepted in the same cycle lands
    flc_select u_select (
        .match_vec (cell_match),
        .values    (cell_value),
        .found     (sel_found),
        .value     (sel_value)
    );

    always_comb begin
        fill_count_next = fill_count_reg;
        if (do_insert && (fill_count_reg != FILL_W'(ENTRIES))) begin
            fill_count_next = fill_count_reg + FILL_W'(1);
        end

        s1_valid_next = s1_valid_reg;
        s1_op_next    = s1_op_reg;
        if (s_ready) begin
            s1_valid_next = s_valid;
            s1_op_next    = s_operation;
        end

        m_valid_next = m_valid_reg;
        m_hit_next   = m_hit_reg;
        m_value_next = m_value_reg;
        if (out_adv) begin
            m_valid_next = s1_valid_reg;
            if (s1_op_reg == OP_LOOKUP && sel_found) begin
                m_hit_next   = 1'b1;
                m_value_next = sel_value;
            end else begin
                m_hit_next   = 1'b0;
                m_value_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_op_reg   <= s1_op_next;
        m_hit_reg   <= m_hit_next;
        m_value_reg <= m_value_next;
        if (!aresetn) begin
            fill_count_reg <= '0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            fill_count_reg <= fill_count_next;
            s1_valid_reg   <= s1_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = m_hit_reg;
    assign m_value_out = m_value_reg;

`ifndef SYNTHESIS
    a_fill_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= FILL_W'(ENTRIES))
        else $error("fill count beyond cache depth");

    a_fill_step : assert property (@(posedge aclk) disable iff (!aresetn)
        (do_insert && fill_count_reg != FILL_W'(ENTRIES))
        |=> fill_count_reg == $past(fill_count_reg) + FILL_W'(1))
        else $error("insert did not grow fill count");

    a_miss_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> m_value_out == '0)
        else $error("miss or insert result carries a value");

    a_stall_only_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled with room in the pipeline");

    a_match_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        do_lookup |=> (cell_match & ~cell_valid) == '0 || $past(do_insert))
        else $error("match flag set on an empty position");
`endif

endmodule : fifo_lookup_cache_top

`default_nettype wire

/* hw/rtl/flc_cell.sv */
// ----------------------------------------------------------------------------
// flc_cell
// One position of the cache chain: holds an entry, takes its neighbour's
// entry on an insert and records whether it matches the current lookup key.
// ----------------------------------------------------------------------------
`default_nettype none

module flc_cell
    import flc_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   shift_en,
    input  wire entry_t entry_in,
    output entry_t      entry_out,
    input  wire logic   entry_valid,
    input  wire logic   lookup_en,
    input  wire key_t   query_key,
    output logic        match_out
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   match_reg;
    logic   match_next;

    always_comb begin
        entry_next = shift_en ? entry_in : entry_reg;
        match_next = match_reg;
        if (lookup_en) begin
            match_next = entry_valid && (entry_reg.key == query_key);
        end
    end

    // entry payload carries no reset, only the match flag does
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign entry_out = entry_reg;
    assign match_out = match_reg;

endmodule : flc_cell

`default_nettype wire

/* hw/rtl/flc_select.sv */
// ----------------------------------------------------------------------------
// flc_select
// Priority select over the cell match flags: picks the newest matching
// position and returns its stored value.
// ----------------------------------------------------------------------------
`default_nettype none

module flc_select
    import flc_pkg::*;
(
    input  wire logic [ENTRIES-1:0] match_vec,
    input  wire logic [VALUE_W-1:0] values [ENTRIES],
    output logic                    found,
    output logic [VALUE_W-1:0]      value
);

    logic [ENTRIES-1:0] first_hot;

    // lowest set bit is the newest match
    assign first_hot = match_vec & (~match_vec + ENTRIES'(1));
    assign found     = |match_vec;

    always_comb begin
        value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            value = value | (values[i] & {VALUE_W{first_hot[i]}});
        end
    end

endmodule : flc_select

`default_nettype wire
